[hw/rtl/tlvs_pkg.sv]
// Package for the two-light vertex shader: shared types, widths and codes.
// Depends on nothing; every module file imports it, the interfaces do not.
package tlvs_pkg;

    localparam int LANES   = 3;
    localparam int LANE_W  = 16;
    localparam int CFG_W   = LANES * LANE_W;
    localparam int PROD_W  = 32;
    localparam int DSUM_W  = 34;
    localparam int DOT_W   = 32;
    localparam int TERM_W  = DOT_W + LANE_W;
    localparam int SUM_W   = TERM_W + 2;
    localparam int CH_W    = 8;
    localparam int SHADE_W = LANES * CH_W;
    localparam int IDX_W   = 3;

    localparam logic [CH_W-1:0]    CH_MAX         = 8'hFF;
    localparam logic [SHADE_W-1:0] SELF_LIT_SHADE = 24'h007FFF;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] CFG_AMBIENT  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_L0_DIR   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_L0_COLOR = 3'd2;
    localparam logic [IDX_W-1:0] CFG_L1_DIR   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_L1_COLOR = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SELF_LIT = 3'd5;

    // Lane 0 sits in the top 16 bits of a register, so the range ascends.
    typedef logic [0:LANES-1][LANE_W-1:0] t_lanes;
    typedef logic [0:LANES-1][CH_W-1:0]   t_shade;
    typedef logic [LANES-1:0][TERM_W-1:0] t_terms;

    typedef struct packed {
        t_lanes ambient;
        t_lanes l0_dir;
        t_lanes l0_color;
        t_lanes l1_dir;
        t_lanes l1_color;
        logic   self_lit;
    } t_cfg;

    // Control that travels with each stage of the pipeline.
    typedef struct packed {
        logic valid;
        logic active;
        logic last;
    } t_tag;

endpackage

[hw/rtl/tlvs_vtx_if.sv]
// Vertex input channel of the two-light vertex shader: valid, ready and normal.
// Depends on nothing.
interface tlvs_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               active;
    logic               last_in;

    modport source (output valid, normal_x, normal_y, normal_z, active, last_in,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, active, last_in,
                    output ready);
endinterface

[hw/rtl/tlvs_shade_if.sv]
// Shade output channel of the two-light vertex shader: valid, ready and colour.
// Depends on nothing.
interface tlvs_shade_if;
    logic        valid;
    logic        ready;
    logic [23:0] shade;
    logic        last_out;

    modport source (output valid, shade, last_out, input ready);
    modport sink   (input valid, shade, last_out, output ready);
endinterface

[hw/rtl/tlvs_cfg.sv]
// Configuration registers of the two-light vertex shader.
// Depends on tlvs_pkg.
module tlvs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [tlvs_pkg::IDX_W-1:0]  i_index,
    input  logic [tlvs_pkg::CFG_W-1:0]  i_data,
    output tlvs_pkg::t_cfg              o_cfg
);
    import tlvs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            unique case (i_index)
                CFG_AMBIENT:  r_cfg.ambient  <= i_data;
                CFG_L0_DIR:   r_cfg.l0_dir   <= i_data;
                CFG_L0_COLOR: r_cfg.l0_color <= i_data;
                CFG_L1_DIR:   r_cfg.l1_dir   <= i_data;
                CFG_L1_COLOR: r_cfg.l1_color <= i_data;
                CFG_SELF_LIT: r_cfg.self_lit <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

[hw/rtl/tlvs_dot.sv]
// Two pipeline stages that form the clamped dot products of the normal with
// both light directions: products first, then the sum and the clamp at zero.
// Depends on tlvs_pkg.
module tlvs_dot (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlvs_pkg::t_tag               i_tag,
    input  logic signed [15:0]           i_nx,
    input  logic signed [15:0]           i_ny,
    input  logic signed [15:0]           i_nz,
    input  tlvs_pkg::t_lanes             i_dir0,
    input  tlvs_pkg::t_lanes             i_dir1,
    output logic                         o_ready,
    input  logic                         i_ready,
    output tlvs_pkg::t_tag               o_tag,
    output logic [tlvs_pkg::DOT_W-1:0]   o_dot0,
    output logic [tlvs_pkg::DOT_W-1:0]   o_dot1
);
    import tlvs_pkg::*;

    logic signed [LANE_W-1:0] w_n [LANES];
    logic signed [PROD_W-1:0] n_prod0 [LANES];
    logic signed [PROD_W-1:0] n_prod1 [LANES];
    logic signed [PROD_W-1:0] r_prod0 [LANES];
    logic signed [PROD_W-1:0] r_prod1 [LANES];
    logic signed [DSUM_W-1:0] w_sum0;
    logic signed [DSUM_W-1:0] w_sum1;
    logic [DOT_W-1:0]         n_dot0;
    logic [DOT_W-1:0]         n_dot1;
    logic [DOT_W-1:0]         r_dot0;
    logic [DOT_W-1:0]         r_dot1;
    t_tag                     r_tag_a;
    t_tag                     r_tag_b;
    logic                     w_acc_a;
    logic                     w_acc_b;

    assign w_acc_b = !r_tag_b.valid || i_ready;
    assign w_acc_a = !r_tag_a.valid || w_acc_b;

    assign w_n[0] = i_nx;
    assign w_n[1] = i_ny;
    assign w_n[2] = i_nz;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_prod0[i] = PROD_W'(w_n[i]) * PROD_W'($signed(i_dir0[i]));
            n_prod1[i] = PROD_W'(w_n[i]) * PROD_W'($signed(i_dir1[i]));
        end
    end

    assign w_sum0 = DSUM_W'(r_prod0[0]) + DSUM_W'(r_prod0[1]) + DSUM_W'(r_prod0[2]);
    assign w_sum1 = DSUM_W'(r_prod1[0]) + DSUM_W'(r_prod1[1]) + DSUM_W'(r_prod1[2]);

    // A light behind the surface contributes nothing; a positive sum fits 32 bits.
    assign n_dot0 = (w_sum0 > 0) ? w_sum0[DOT_W-1:0] : '0;
    assign n_dot1 = (w_sum1 > 0) ? w_sum1[DOT_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else begin
            if (w_acc_a) begin
                r_tag_a <= i_tag;
            end
            if (w_acc_b) begin
                r_tag_b <= r_tag_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_a) begin
            r_prod0 <= n_prod0;
            r_prod1 <= n_prod1;
        end
        if (w_acc_b) begin
            r_dot0 <= n_dot0;
            r_dot1 <= n_dot1;
        end
    end

    assign o_ready = w_acc_a;
    assign o_tag   = r_tag_b;
    assign o_dot0  = r_dot0;
    assign o_dot1  = r_dot1;
endmodule

[hw/rtl/tlvs_scale.sv]
// Pipeline stage that scales each light colour by its clamped dot product.
// Depends on tlvs_pkg.
module tlvs_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlvs_pkg::t_tag              i_tag,
    input  logic [tlvs_pkg::DOT_W-1:0]  i_dot0,
    input  logic [tlvs_pkg::DOT_W-1:0]  i_dot1,
    input  tlvs_pkg::t_lanes            i_color0,
    input  tlvs_pkg::t_lanes            i_color1,
    output logic                        o_ready,
    input  logic                        i_ready,
    output tlvs_pkg::t_tag              o_tag,
    output tlvs_pkg::t_terms            o_term0,
    output tlvs_pkg::t_terms            o_term1
);
    import tlvs_pkg::*;

    t_terms n_term0;
    t_terms n_term1;
    t_terms r_term0;
    t_terms r_term1;
    t_tag   r_tag;
    logic   w_acc;

    assign w_acc = !r_tag.valid || i_ready;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_term0[i] = TERM_W'(i_dot0) * TERM_W'(i_color0[i]);
            n_term1[i] = TERM_W'(i_dot1) * TERM_W'(i_color1[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (w_acc) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_term0 <= n_term0;
            r_term1 <= n_term1;
        end
    end

    assign o_ready = w_acc;
    assign o_tag   = r_tag;
    assign o_term0 = r_term0;
    assign o_term1 = r_term1;
endmodule

[hw/rtl/tlvs_pack.sv]
// Output stage: adds ambient and both light terms, saturates each channel to
// eight bits and packs the shade. Depends on tlvs_pkg.
module tlvs_pack #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlvs_pkg::t_tag                i_tag,
    input  tlvs_pkg::t_terms              i_term0,
    input  tlvs_pkg::t_terms              i_term1,
    input  tlvs_pkg::t_lanes              i_ambient,
    input  logic                          i_self_lit,
    output logic                          o_ready,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [tlvs_pkg::SHADE_W-1:0]  o_shade,
    output logic                          o_last
);
    import tlvs_pkg::*;

    // Sums carry 3F fraction bits; eight of them survive as the channel.
    localparam int SHIFT = 3 * FRAC_BITS - CH_W;

    logic [SUM_W-1:0]   w_sum  [LANES];
    logic [SUM_W-1:0]   w_full [LANES];
    t_shade             w_ch;
    logic [SHADE_W-1:0] n_shade;
    logic [SHADE_W-1:0] r_shade;
    logic               r_last;
    logic               r_valid;
    logic               w_acc;

    assign w_acc = !r_valid || i_ready;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_sum[i]  = (SUM_W'(i_ambient[i]) << (2 * FRAC_BITS))
                      + SUM_W'(i_term0[i]) + SUM_W'(i_term1[i]);
            w_full[i] = w_sum[i] >> SHIFT;
            w_ch[i]   = (|w_full[i][SUM_W-1:CH_W]) ? CH_MAX : w_full[i][CH_W-1:0];
        end
    end

    always_comb begin
        priority if (i_self_lit) begin
            n_shade = SELF_LIT_SHADE;
        end else if (!i_tag.active) begin
            n_shade = '0;
        end else begin
            n_shade = w_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_shade <= n_shade;
            r_last  <= i_tag.last;
        end
    end

    assign o_ready = w_acc;
    assign o_valid = r_valid;
    assign o_shade = r_shade;
    assign o_last  = r_last;
endmodule

[hw/rtl/two_light_vertex_shader.sv]
// Two-light Lambert vertex shader: each vertex normal gives one packed 24-bit
// shade, ambient plus both directional light colours weighted by the clamped
// dot products, each channel saturated and truncated to eight bits (a constant
// in self-lit mode, zero for an inactive vertex). The block takes one vertex
// per clock while the output does not stall and holds up to four in flight,
// one in each of its four register stages (direction products, dot sums,
// colour multipliers, channel sum and pack). A stall on the output stops the
// stages back to the input through the ready chain without losing data. The
// user must write configuration only while idle; the block does not enforce it.
// Depends on tlvs_pkg, tlvs_vtx_if, tlvs_shade_if and the tlvs_* stages.
module two_light_vertex_shader #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tlvs_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [tlvs_pkg::CFG_W-1:0]  i_cfg_data,
    tlvs_vtx_if.sink                    i_vtx,
    tlvs_shade_if.source                o_shade
);
    import tlvs_pkg::*;

    t_cfg               w_cfg;
    t_tag               w_in_tag;
    t_tag               w_dot_tag;
    t_tag               w_scale_tag;
    logic [DOT_W-1:0]   w_dot0;
    logic [DOT_W-1:0]   w_dot1;
    t_terms             w_term0;
    t_terms             w_term1;
    logic               w_dot_ready;
    logic               w_scale_ready;
    logic               w_pack_ready;

    assign w_in_tag.valid  = i_vtx.valid;
    assign w_in_tag.active = i_vtx.active;
    assign w_in_tag.last   = i_vtx.last_in;

    tlvs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    tlvs_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_in_tag),
        .i_nx    (i_vtx.normal_x),
        .i_ny    (i_vtx.normal_y),
        .i_nz    (i_vtx.normal_z),
        .i_dir0  (w_cfg.l0_dir),
        .i_dir1  (w_cfg.l1_dir),
        .o_ready (w_dot_ready),
        .i_ready (w_scale_ready),
        .o_tag   (w_dot_tag),
        .o_dot0  (w_dot0),
        .o_dot1  (w_dot1)
    );

    tlvs_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_dot_tag),
        .i_dot0   (w_dot0),
        .i_dot1   (w_dot1),
        .i_color0 (w_cfg.l0_color),
        .i_color1 (w_cfg.l1_color),
        .o_ready  (w_scale_ready),
        .i_ready  (w_pack_ready),
        .o_tag    (w_scale_tag),
        .o_term0  (w_term0),
        .o_term1  (w_term1)
    );

    tlvs_pack #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_scale_tag),
        .i_term0    (w_term0),
        .i_term1    (w_term1),
        .i_ambient  (w_cfg.ambient),
        .i_self_lit (w_cfg.self_lit),
        .o_ready    (w_pack_ready),
        .i_ready    (o_shade.ready),
        .o_valid    (o_shade.valid),
        .o_shade    (o_shade.shade),
        .o_last     (o_shade.last_out)
    );

    assign i_vtx.ready = w_dot_ready;

`ifndef NO_ASSERTIONS
    // With the output stage empty, every stage can move, so input is accepted.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_shade.valid |-> i_vtx.ready)
        else $error("input not ready while output stage is empty");

    // Self-lit mode overrides every shade.
    a_self_lit_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_shade.valid && w_cfg.self_lit) |-> (o_shade.shade == SELF_LIT_SHADE))
        else $error("self-lit shade differs from the constant");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_shade.valid)
        else $error("output valid straight after reset");
`endif
endmodule

[bench/two_light_vertex_shader_test.sv]
// Self-checking testbench for the two-light vertex shader: directed lighting cases, then a long
// random vertex stream under several register settings, with random gaps and output stalls.
// Depends on tlvs_pkg, tlvs_vtx_if, tlvs_shade_if and the two_light_vertex_shader top level.
`timescale 1ns / 1ps

module two_light_vertex_shader_test;
    import tlvs_pkg::*;

    localparam int FRAC_BITS   = 14;
    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 6;
    localparam int PIPE_DEPTH  = 4;
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam int MAX_REPORTS = 20;
    localparam int N_PHASES    = 8;
    localparam int PHASE_LEN   = 150;
    localparam int CALM_PHASES = 2;

    // Indexes past the register list; writes to them must leave every register alone.
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [LANE_W-1:0] nx;
        logic signed [LANE_W-1:0] ny;
        logic signed [LANE_W-1:0] nz;
        logic                     active;
        logic                     last;
    } t_vertex;

    typedef struct {
        logic [SHADE_W-1:0] shade;
        logic               last;
    } t_lit_vertex;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    tlvs_vtx_if   vtx ();
    tlvs_shade_if shd ();

    two_light_vertex_shader #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_vtx       (vtx),
        .o_shade     (shd)
    );

    t_cfg        light_setup;
    t_lit_vertex expected_shades [$];
    int          mismatch_count;
    bit          sender_gaps;
    bit          sink_stalls;
    int          stall_left;

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        vtx.valid    = 1'b0;
        vtx.normal_x = '0;
        vtx.normal_y = '0;
        vtx.normal_z = '0;
        vtx.active   = 1'b0;
        vtx.last_in  = 1'b0;
        shd.ready    = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    // Output back-pressure: random bursts of stalled cycles when enabled.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            shd.ready  <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            shd.ready  <= 1'b0;
        end else begin
            shd.ready  <= 1'b1;
        end
    end

    function automatic longint light_dot(t_vertex v, t_lanes dir);
        return longint'(v.nx) * longint'($signed(dir[0]))
             + longint'(v.ny) * longint'($signed(dir[1]))
             + longint'(v.nz) * longint'($signed(dir[2]));
    endfunction

    function automatic logic [SHADE_W-1:0] predict_shade(t_cfg c, t_vertex v);
        longint d0;
        longint d1;
        longint acc;
        longint level;
        t_shade ch;
        int     i;
        if (c.self_lit)
            return SELF_LIT_SHADE;
        if (!v.active)
            return '0;
        d0 = light_dot(v, c.l0_dir);
        d1 = light_dot(v, c.l1_dir);
        for (i = 0; i < LANES; i++) begin
            acc = longint'(c.ambient[i]) <<< (2 * FRAC_BITS);
            // A light facing away, or edge-on, adds nothing.
            if (d0 > 0)
                acc += d0 * longint'(c.l0_color[i]);
            if (d1 > 0)
                acc += d1 * longint'(c.l1_color[i]);
            level = acc >>> (3 * FRAC_BITS - CH_W);
            ch[i] = (level > longint'(CH_MAX)) ? CH_MAX : level[CH_W-1:0];
        end
        return ch;
    endfunction

    task automatic report_mismatch(string what, logic [SHADE_W-1:0] got,
                                   logic [SHADE_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_lit_vertex want;
        if (i_rst_n === 1'b1 && shd.valid === 1'b1 && shd.ready === 1'b1) begin
            if (expected_shades.size() == 0) begin
                report_mismatch("unexpected shade transaction", shd.shade, '0);
            end else begin
                want = expected_shades.pop_front();
                if (shd.shade !== want.shade)
                    report_mismatch("shade", shd.shade, want.shade);
                if (shd.last_out !== want.last)
                    report_mismatch("last_out", 24'(shd.last_out), 24'(want.last));
            end
        end
    end

    task automatic send_vertex(t_vertex v);
        int gap;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            vtx.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
        vtx.valid    <= 1'b1;
        vtx.normal_x <= v.nx;
        vtx.normal_y <= v.ny;
        vtx.normal_z <= v.nz;
        vtx.active   <= v.active;
        vtx.last_in  <= v.last;
        do @(posedge i_clk); while (vtx.ready !== 1'b1);
        expected_shades.push_back('{predict_shade(light_setup, v), v.last});
    endtask

    // Stops sending and waits until the pipeline has emptied.
    task automatic wait_for_shades();
        vtx.valid <= 1'b0;
        wait (expected_shades.size() == 0);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_AMBIENT:  light_setup.ambient  = data;
            CFG_L0_DIR:   light_setup.l0_dir   = data;
            CFG_L0_COLOR: light_setup.l0_color = data;
            CFG_L1_DIR:   light_setup.l1_dir   = data;
            CFG_L1_COLOR: light_setup.l1_color = data;
            CFG_SELF_LIT: light_setup.self_lit = data[0];
            default: ;
        endcase
    endtask

    // Writes every register; the upper bits of the self-lit word are noise the block must ignore.
    task automatic load_config(t_cfg c);
        logic [CFG_W-1:0] lit_word;
        wait_for_shades();
        lit_word = {16'($urandom()), 31'($urandom()), c.self_lit};
        write_reg(CFG_AMBIENT,  c.ambient);
        write_reg(CFG_L0_DIR,   c.l0_dir);
        write_reg(CFG_L0_COLOR, c.l0_color);
        write_reg(CFG_L1_DIR,   c.l1_dir);
        write_reg(CFG_L1_COLOR, c.l1_color);
        write_reg(CFG_SELF_LIT, lit_word);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_vertex make_vertex(int nx, int ny, int nz, bit active, bit last);
        t_vertex v;
        v.nx     = nx[LANE_W-1:0];
        v.ny     = ny[LANE_W-1:0];
        v.nz     = nz[LANE_W-1:0];
        v.active = active;
        v.last   = last;
        return v;
    endfunction

    function automatic logic [LANE_W-1:0] random_q14_signed();
        int v;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'h4000;
            2:       return 16'hC000;
            3:       return 16'h8000;
            4:       return 16'h7FFF;
            default: begin
                v = int'($urandom_range(0, 32768)) - 16384;
                return v[LANE_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [LANE_W-1:0] random_color();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h4000;
            default: return 16'($urandom_range(0, 16'h3000));
        endcase
    endfunction

    function automatic t_cfg random_config(bit lit);
        t_cfg c;
        int   i;
        for (i = 0; i < LANES; i++) begin
            c.ambient[i]  = random_color() >> $urandom_range(0, 2);
            c.l0_dir[i]   = random_q14_signed();
            c.l0_color[i] = random_color();
            c.l1_dir[i]   = random_q14_signed();
            c.l1_color[i] = random_color();
        end
        c.self_lit = lit;
        return c;
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex v;
        // A few normals use the whole 16-bit code space, out of range included.
        if ($urandom_range(0, 9) == 0) begin
            v.nx = 16'($urandom());
            v.ny = 16'($urandom());
            v.nz = 16'($urandom());
        end else begin
            v.nx = random_q14_signed();
            v.ny = random_q14_signed();
            v.nz = random_q14_signed();
        end
        v.active = ($urandom_range(0, 3) != 0);
        v.last   = ($urandom_range(0, 15) == 0);
        return v;
    endfunction

    task automatic test_after_reset();
        send_vertex(make_vertex(16384, 16384, 16384, 1'b1, 1'b0));
        send_vertex(make_vertex(-16384, 0, 16384, 1'b1, 1'b0));
        send_vertex(make_vertex(0, 0, 0, 1'b0, 1'b1));
    endtask

    task automatic test_directed_lighting();
        t_cfg c;
        c.ambient  = {16'h3FFF, 16'h2000, 16'h0000};
        c.l0_dir   = {16'h4000, 16'h0000, 16'h0000};
        c.l0_color = {16'h1000, 16'h2000, 16'hFFFF};
        c.l1_dir   = {16'h0000, 16'hC000, 16'h0000};
        c.l1_color = {16'h4000, 16'h0100, 16'h0000};
        c.self_lit = 1'b0;
        load_config(c);
        send_vertex(make_vertex(16384, 0, 0, 1'b1, 1'b0));
        send_vertex(make_vertex(0, -16384, 0, 1'b1, 1'b0));
        // Facing away from light 0 and edge-on to light 1: ambient alone.
        send_vertex(make_vertex(-16384, 0, 0, 1'b1, 1'b0));
        send_vertex(make_vertex(0, 0, 0, 1'b1, 1'b0));
        send_vertex(make_vertex(16384, -16384, 16384, 1'b1, 1'b0));
        send_vertex(make_vertex(-32768, 32767, -32768, 1'b1, 1'b0));
        send_vertex(make_vertex(32767, -32768, 32767, 1'b1, 1'b0));
        send_vertex(make_vertex(16384, -16384, 0, 1'b0, 1'b1));
    endtask

    task automatic test_saturation();
        t_cfg c;
        c = '1;
        c.self_lit = 1'b0;
        load_config(c);
        send_vertex(make_vertex(-16384, -16384, -16384, 1'b1, 1'b0));
        send_vertex(make_vertex(16384, 16384, 16384, 1'b1, 1'b1));
        c = '0;
        load_config(c);
        send_vertex(make_vertex(16384, -16384, 16384, 1'b1, 1'b0));
        send_vertex(make_vertex(-32768, -32768, -32768, 1'b1, 1'b1));
    endtask

    task automatic test_self_lit();
        load_config(random_config(1'b1));
        send_vertex(make_vertex(16384, 16384, 16384, 1'b1, 1'b0));
        send_vertex(make_vertex(-16384, 0, 0, 1'b0, 1'b1));
        send_vertex(random_vertex());
        load_config(random_config(1'b0));
        send_vertex(make_vertex(16384, 16384, 16384, 1'b1, 1'b0));
    endtask

    task automatic test_spare_index();
        wait_for_shades();
        write_reg(CFG_SPARE_LO, {16'($urandom()), 32'($urandom())});
        write_reg(CFG_SPARE_HI, '1);
        i_cfg_we <= 1'b0;
        send_vertex(make_vertex(16384, 16384, 16384, 1'b1, 1'b0));
        send_vertex(make_vertex(-16384, 16384, -16384, 1'b1, 1'b1));
    endtask

    task automatic test_random_stream();
        int  phase;
        int  n;
        bit  calm;
        for (phase = 0; phase < N_PHASES; phase++) begin
            calm = (phase >= N_PHASES - CALM_PHASES);
            sender_gaps = 1'b0;
            sink_stalls = 1'b0;
            load_config(random_config($urandom_range(0, 5) == 0));
            for (n = 0; n < PHASE_LEN; n++) begin
                if (!calm && n % 50 == 0) begin
                    sender_gaps = ($urandom_range(0, 3) != 0);
                    sink_stalls = ($urandom_range(0, 3) != 0);
                end
                // Once mid-phase, the sender holds off until every shade is back.
                if (phase == 1 && n == PHASE_LEN / 2)
                    wait_for_shades();
                send_vertex(random_vertex());
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        light_setup    = '0;
        sender_gaps    = 1'b1;
        sink_stalls    = 1'b1;
        stall_left     = 0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_directed_lighting();
        test_saturation();
        test_self_lit();
        test_spare_index();
        test_random_stream();

        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        wait_for_shades();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tlvs_pkg.sv
hw/rtl/tlvs_vtx_if.sv
hw/rtl/tlvs_shade_if.sv
hw/rtl/tlvs_cfg.sv
hw/rtl/tlvs_dot.sv
hw/rtl/tlvs_scale.sv
hw/rtl/tlvs_pack.sv
hw/rtl/two_light_vertex_shader.sv
bench/two_light_vertex_shader_test.sv
